[hw/rtl/qlte_pkg.sv]
// ----------------------------------------------------------------------------
// qlte_pkg
// Shared types and constants of the Q-learning table engine: table geometry,
// datapath widths, request and result records, register and operation codes.
// ----------------------------------------------------------------------------
package qlte_pkg;

    localparam int NUM_STATES  = 16;
    localparam int NUM_ACTIONS = 2;
    localparam int STATE_W     = $clog2(NUM_STATES);
    localparam int ACT_W       = $clog2(NUM_ACTIONS);
    localparam int ADDR_W      = STATE_W + ACT_W;
    localparam int TBL_DEPTH   = NUM_STATES * NUM_ACTIONS;

    localparam int IN_STATE_W  = 4;
    localparam int IN_ACT_W    = 1;
    localparam int REW_W       = 16;
    localparam int DRAW_W      = 16;
    localparam int COEF_W      = 16;
    localparam int Q_W         = 24;

    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    localparam int MUL_A_W     = COEF_W + 1;
    localparam int MUL_B_W     = Q_W + 1;
    localparam int MUL_P_W     = MUL_A_W + MUL_B_W;
    localparam int INNER_W     = 42;
    localparam int SPLIT_W     = 21;
    localparam int ACC_W       = 60;
    localparam int FRAC_SHIFT  = 32;
    localparam int SUM_W       = ACC_W - FRAC_SHIFT + 1;

    localparam logic signed [Q_W-1:0] Q_POS_MAX = {1'b0, {(Q_W-1){1'b1}}};
    localparam logic signed [Q_W-1:0] Q_NEG_MIN = {1'b1, {(Q_W-1){1'b0}}};

    localparam logic OP_CHOOSE   = 1'b0;
    localparam logic OP_UPDATE   = 1'b1;
    localparam logic KIND_CHOOSE = 1'b0;
    localparam logic KIND_UPDATE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_EPSILON  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAMMA    = 2'd2;

    localparam logic [COEF_W-1:0] EPSILON_RST = 16'd13107;
    localparam logic [COEF_W-1:0] ALPHA_RST   = 16'd58982;
    localparam logic [COEF_W-1:0] GAMMA_RST   = 16'd58982;

    typedef struct packed {
        logic                     operation;
        logic [IN_STATE_W-1:0]    state_index;
        logic [IN_ACT_W-1:0]      action;
        logic signed [REW_W-1:0]  reward;
        logic [IN_STATE_W-1:0]    succ_state;
        logic                     update_all;
        logic [DRAW_W-1:0]        explore_draw;
        logic [IN_ACT_W-1:0]      explore_act;
        logic [DRAW_W-1:0]        tie_draw;
    } in_item_t;

    typedef struct packed {
        logic                     kind;
        logic [IN_ACT_W-1:0]      chosen_action;
        logic                     explored;
        logic signed [Q_W-1:0]    q_value;
        logic                     saturated;
        logic                     last;
    } out_item_t;

    typedef struct packed {
        logic                     wr_en;
        logic [ADDR_W-1:0]        wr_addr;
        logic signed [Q_W-1:0]    wr_data;
        logic [ADDR_W-1:0]        rd_addr;
    } tbl_req_t;

endpackage

[hw/rtl/q_learning_table_engine.sv]
// ----------------------------------------------------------------------------
// q_learning_table_engine
// Tabular Q-learning engine with epsilon-greedy action choice.
// ----------------------------------------------------------------------------
// Requests arrive on s_valid/s_ready/s_data; results leave on
// m_valid/m_ready/m_data through an output register. Registers (epsilon,
// learning rate, discount) are written on cfg_valid/cfg_ready/cfg_index/
// cfg_data, always ready; indexes past the list are dropped.
// One request is worked at a time and s_ready is high only between requests.
// The sequencer reads the table through one registered read port and runs
// all products through one 17x25 multiplier:
//   choose, exploring:    result loaded straight from the request
//   choose, greedy:       both row entries read and compared, then result
//   update, one action:   row peak, discount, inner, low and high halves, sum
//   update, all actions:  discount through write repeat per further action
// A new request is taken the cycle after the last result is loaded.
// Reset clears the table to zero (per-entry valid bits, no clearing pass)
// and loads the register defaults. When m_ready is low, a finished result
// holds in the output register and the sequencer waits before loading the
// next one; the table write of an update waits with its result.
// ----------------------------------------------------------------------------
module q_learning_table_engine (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  qlte_pkg::in_item_t                    s_data,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output qlte_pkg::out_item_t                   m_data,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [qlte_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [qlte_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import qlte_pkg::*;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_RD0    = 4'd1;
    localparam logic [3:0] ST_RD1    = 4'd2;
    localparam logic [3:0] ST_RD2    = 4'd3;
    localparam logic [3:0] ST_MUL_G  = 4'd4;
    localparam logic [3:0] ST_INNER  = 4'd5;
    localparam logic [3:0] ST_MUL_LO = 4'd6;
    localparam logic [3:0] ST_MUL_HI = 4'd7;
    localparam logic [3:0] ST_SUM    = 4'd8;
    localparam logic [3:0] ST_WB     = 4'd9;
    localparam logic [3:0] ST_CH_OUT = 4'd10;

    logic [3:0]              state_reg, state_next;
    in_item_t                in_reg;
    logic [ACT_W-1:0]        act_reg;
    logic                    explored_reg;
    logic signed [Q_W-1:0]   max_reg;
    logic signed [Q_W-1:0]   q_cur_reg;
    logic signed [INNER_W-1:0] inner_reg;
    logic signed [INNER_W-1:0] inner_next;
    logic signed [MUL_P_W-1:0] lo_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;
    logic [COEF_W-1:0]       eps_reg, alpha_reg, gamma_reg;
    logic                    m_valid_reg;
    out_item_t               m_data_reg;
    out_item_t               out_next;

    logic [STATE_W-1:0]      row_w, st_w;
    logic [ACT_W-1:0]        act_inc;
    logic                    is_last;
    logic                    out_free;
    logic                    out_load;
    logic                    accept;
    logic                    explore_now;
    logic [ACT_W-1:0]        greedy_act;

    tbl_req_t                tbl_req;
    logic signed [Q_W-1:0]   tbl_q;

    logic                    mul_en;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] mul_p;

    logic signed [SUM_W-1:0] sum_w;
    logic signed [Q_W-1:0]   new_q;
    logic                    new_sat;

    qlte_table u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (tbl_req),
        .rd_q    (tbl_q)
    );

    qlte_mul u_mul (
        .aclk  (aclk),
        .en    (mul_en),
        .a     (mul_a),
        .b     (mul_b),
        .p_reg (mul_p)
    );

    assign s_ready     = (state_reg == ST_IDLE);
    assign accept      = s_valid && s_ready;
    assign cfg_ready   = 1'b1;
    assign m_valid     = m_valid_reg;
    assign m_data      = m_data_reg;
    assign explore_now = (s_data.operation == OP_CHOOSE) && (s_data.explore_draw < eps_reg);

    assign row_w    = (in_reg.operation == OP_UPDATE) ? in_reg.succ_state[STATE_W-1:0]
                                                      : in_reg.state_index[STATE_W-1:0];
    assign st_w     = in_reg.state_index[STATE_W-1:0];
    assign act_inc  = act_reg + ACT_W'(1);
    assign is_last  = !in_reg.update_all || (act_reg == ACT_W'(NUM_ACTIONS - 1));
    assign out_free = !m_valid_reg || m_ready;
    assign out_load = ((state_reg == ST_WB) || (state_reg == ST_CH_OUT)) && out_free;

    always_comb begin
        if (tbl_q > max_reg) begin
            greedy_act = ACT_W'(1);
        end else if (max_reg > tbl_q) begin
            greedy_act = ACT_W'(0);
        end else begin
            greedy_act = in_reg.tie_draw[ACT_W-1:0];
        end
    end

    always_comb begin
        tbl_req.wr_en   = (state_reg == ST_WB) && out_free;
        tbl_req.wr_addr = {st_w, act_reg};
        tbl_req.wr_data = new_q;
        unique case (state_reg)
            ST_RD0:  tbl_req.rd_addr = {row_w, ACT_W'(0)};
            ST_RD1:  tbl_req.rd_addr = {row_w, ACT_W'(1)};
            ST_WB:   tbl_req.rd_addr = {st_w, act_inc};
            default: tbl_req.rd_addr = {st_w, act_reg};
        endcase
    end

    always_comb begin
        mul_en = 1'b0;
        mul_a  = MUL_A_W'({1'b0, alpha_reg});
        mul_b  = MUL_B_W'(max_reg);
        unique case (state_reg)
            ST_MUL_G: begin
                mul_en = 1'b1;
                mul_a  = MUL_A_W'({1'b0, gamma_reg});
            end
            ST_MUL_LO: begin
                mul_en = 1'b1;
                mul_b  = MUL_B_W'({1'b0, inner_reg[SPLIT_W-1:0]});
            end
            ST_MUL_HI: begin
                mul_en = 1'b1;
                mul_b  = MUL_B_W'($signed(inner_reg[INNER_W-1:SPLIT_W]));
            end
            default: mul_en = 1'b0;
        endcase
    end

    assign inner_next = (INNER_W'($signed(in_reg.reward)) <<< COEF_W) + INNER_W'(mul_p)
                      - (INNER_W'(q_cur_reg) <<< COEF_W);
    assign acc_next   = (ACC_W'(mul_p) <<< SPLIT_W) + ACC_W'(lo_reg)
                      + (ACC_W'(1) <<< (FRAC_SHIFT - 1));
    assign sum_w      = SUM_W'(q_cur_reg) + SUM_W'($signed(acc_reg[ACC_W-1:FRAC_SHIFT]));

    always_comb begin
        new_sat = 1'b0;
        new_q   = sum_w[Q_W-1:0];
        if (sum_w > SUM_W'(Q_POS_MAX)) begin
            new_q   = Q_POS_MAX;
            new_sat = 1'b1;
        end else if (sum_w < SUM_W'(Q_NEG_MIN)) begin
            new_q   = Q_NEG_MIN;
            new_sat = 1'b1;
        end
    end

    always_comb begin
        if (state_reg == ST_WB) begin
            out_next.kind          = KIND_UPDATE;
            out_next.chosen_action = act_reg;
            out_next.explored      = 1'b0;
            out_next.q_value       = new_q;
            out_next.saturated     = new_sat;
            out_next.last          = is_last;
        end else begin
            out_next.kind          = KIND_CHOOSE;
            out_next.chosen_action = act_reg;
            out_next.explored      = explored_reg;
            out_next.q_value       = '0;
            out_next.saturated     = 1'b0;
            out_next.last          = 1'b1;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = explore_now ? ST_CH_OUT : ST_RD0;
                end
            end
            ST_RD0:    state_next = ST_RD1;
            ST_RD1:    state_next = ST_RD2;
            ST_RD2:    state_next = (in_reg.operation == OP_UPDATE) ? ST_MUL_G : ST_CH_OUT;
            ST_MUL_G:  state_next = ST_INNER;
            ST_INNER:  state_next = ST_MUL_LO;
            ST_MUL_LO: state_next = ST_MUL_HI;
            ST_MUL_HI: state_next = ST_SUM;
            ST_SUM:    state_next = ST_WB;
            ST_WB: begin
                if (out_free) begin
                    state_next = is_last ? ST_IDLE : ST_MUL_G;
                end
            end
            ST_CH_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            eps_reg     <= EPSILON_RST;
            alpha_reg   <= ALPHA_RST;
            gamma_reg   <= GAMMA_RST;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    CFG_EPSILON: eps_reg   <= cfg_data;
                    CFG_ALPHA:   alpha_reg <= cfg_data;
                    CFG_GAMMA:   gamma_reg <= cfg_data;
                    default:     eps_reg   <= eps_reg;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg <= out_next;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    in_reg       <= s_data;
                    explored_reg <= (s_data.operation == OP_CHOOSE);
                    if (s_data.operation == OP_CHOOSE) begin
                        act_reg <= s_data.explore_act[ACT_W-1:0];
                    end else if (s_data.update_all) begin
                        act_reg <= '0;
                    end else begin
                        act_reg <= s_data.action[ACT_W-1:0];
                    end
                end
            end
            ST_RD1: max_reg <= tbl_q;
            ST_RD2: begin
                if (in_reg.operation == OP_UPDATE) begin
                    if (tbl_q > max_reg) begin
                        max_reg <= tbl_q;
                    end
                end else begin
                    act_reg      <= greedy_act;
                    explored_reg <= 1'b0;
                end
            end
            ST_MUL_G:  q_cur_reg <= tbl_q;
            ST_INNER:  inner_reg <= inner_next;
            ST_MUL_HI: lo_reg    <= mul_p;
            ST_SUM:    acc_reg   <= acc_next;
            ST_WB: begin
                if (out_free) begin
                    act_reg <= act_inc;
                end
            end
            default: act_reg <= act_reg;
        endcase
    end

    a_choose_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.kind == KIND_CHOOSE) |->
            (m_data.q_value == '0) && !m_data.saturated && m_data.last)
        else $error("choose result carries update fields");

    a_sat_extreme: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.saturated |->
            (m_data.q_value == Q_POS_MAX) || (m_data.q_value == Q_NEG_MIN))
        else $error("saturated result not at range limit");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_ready)
        else $error("request taken while another is in work");

    a_single_action: assert property (@(posedge aclk) disable iff (!aresetn)
        tbl_req.wr_en && !in_reg.update_all |->
            (act_reg == in_reg.action[ACT_W-1:0]) && is_last)
        else $error("single update writes the wrong action");

endmodule

[hw/rtl/qlte_table.sv]
// ----------------------------------------------------------------------------
// qlte_table
// Q value store: one write and one registered read per cycle. Entries not
// yet written since reset read as zero through per-entry valid bits.
// ----------------------------------------------------------------------------
module qlte_table (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  qlte_pkg::tbl_req_t              req,
    output logic signed [qlte_pkg::Q_W-1:0] rd_q
);
    import qlte_pkg::*;

    logic signed [Q_W-1:0] mem [TBL_DEPTH];
    logic [TBL_DEPTH-1:0]  valid_reg;
    logic signed [Q_W-1:0] rd_data_reg;
    logic                  rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
        rd_data_reg <= mem[req.rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (req.wr_en) begin
                valid_reg[req.wr_addr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[req.rd_addr];
        end
    end

    assign rd_q = rd_valid_reg ? rd_data_reg : '0;

endmodule

[hw/rtl/qlte_mul.sv]
// ----------------------------------------------------------------------------
// qlte_mul
// Shared signed multiplier with registered product, reused for the discount
// product and both halves of the learning-rate product.
// ----------------------------------------------------------------------------
module qlte_mul (
    input  logic                                aclk,
    input  logic                                en,
    input  logic signed [qlte_pkg::MUL_A_W-1:0] a,
    input  logic signed [qlte_pkg::MUL_B_W-1:0] b,
    output logic signed [qlte_pkg::MUL_P_W-1:0] p_reg
);
    import qlte_pkg::*;

    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg <= MUL_P_W'(a * b);
        end
    end

endmodule

[bench/q_learning_table_engine_tb.sv]
// ----------------------------------------------------------------------------
// q_learning_table_engine_tb
// Self-checking bench for the Q-learning table engine. A shadow Q table and
// shadow registers predict every choose and update result, which the result
// monitor compares field by field in order. Requests and results stall at
// random, the register set sweeps its extremes, ramps push entries into
// positive and negative clipping, and a long result stall backs up requests.
// ----------------------------------------------------------------------------
module q_learning_table_engine_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import qlte_pkg::*;

    localparam int     IDLE_PCT     = 23;
    localparam int     SETTLE       = 4;
    localparam int     HOLD_LEN     = 300;
    localparam int     RAMP_LEN     = 420;
    localparam int     MIX_LEN      = 110;
    localparam longint RUN_LIMIT_NS = 4_000_000;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_valid   = 1'b0;
    logic                   s_ready;
    in_item_t               s_data    = '0;
    logic                   m_valid;
    logic                   m_ready   = 1'b0;
    out_item_t              m_data;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    logic signed [Q_W-1:0]  q_shadow [TBL_DEPTH] = '{default: '0};
    logic [COEF_W-1:0]      eps_reg   = EPSILON_RST;
    logic [COEF_W-1:0]      alpha_reg = ALPHA_RST;
    logic [COEF_W-1:0]      gamma_reg = GAMMA_RST;
    out_item_t              pending_results [$];

    bit gaps_on         = 1'b1;
    int rx_hold_left    = 0;
    int error_count     = 0;
    int request_count   = 0;
    int reg_write_count = 0;
    int choose_count    = 0;
    int explore_count   = 0;
    int update_count    = 0;
    int clip_count      = 0;

    q_learning_table_engine dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (rx_hold_left > 0) begin
            rx_hold_left = rx_hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= !(gaps_on && $urandom_range(99) < IDLE_PCT);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            check_result(m_data);
        end
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        if (error_count < 50) begin
            $display("%0t ns: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        end
        error_count++;
    endtask

    task automatic check_result(input out_item_t got);
        out_item_t want;
        if (pending_results.size() == 0) begin
            report_mismatch("result with nothing expected", got, 0);
            return;
        end
        want = pending_results.pop_front();
        if (got.kind !== want.kind) report_mismatch("kind", got.kind, want.kind);
        if (got.chosen_action !== want.chosen_action) begin
            report_mismatch("chosen_action", got.chosen_action, want.chosen_action);
        end
        if (got.explored !== want.explored) report_mismatch("explored", got.explored, want.explored);
        if (got.q_value !== want.q_value) report_mismatch("q_value", got.q_value, want.q_value);
        if (got.saturated !== want.saturated) begin
            report_mismatch("saturated", got.saturated, want.saturated);
        end
        if (got.last !== want.last) report_mismatch("last", got.last, want.last);
        if (want.kind == KIND_CHOOSE) begin
            choose_count++;
            if (want.explored) explore_count++;
        end else begin
            update_count++;
            if (want.saturated) clip_count++;
        end
    endtask

    function automatic logic signed [Q_W-1:0] row_peak(input int st);
        logic signed [Q_W-1:0] peak;
        peak = q_shadow[st * NUM_ACTIONS];
        for (int a = 1; a < NUM_ACTIONS; a++) begin
            if (q_shadow[st * NUM_ACTIONS + a] > peak) peak = q_shadow[st * NUM_ACTIONS + a];
        end
        return peak;
    endfunction

    // Q + alpha*(reward + gamma*peak - Q), rounded half up once, then clipped
    function automatic logic signed [Q_W-1:0] learned_value(
        input  logic signed [Q_W-1:0]   q,
        input  logic signed [Q_W-1:0]   peak,
        input  logic signed [REW_W-1:0] reward,
        output logic                    clipped
    );
        longint q64, p64, r64, a64, g64, inner, delta, nv;
        q64 = q;
        p64 = peak;
        r64 = reward;
        a64 = alpha_reg;
        g64 = gamma_reg;
        inner = r64 * 65536 + g64 * p64 - q64 * 65536;
        delta = (a64 * inner + 64'sh8000_0000) >>> 32;
        nv = q64 + delta;
        clipped = 1'b0;
        if (nv > longint'(Q_POS_MAX)) begin
            nv = Q_POS_MAX;
            clipped = 1'b1;
        end
        if (nv < longint'(Q_NEG_MIN)) begin
            nv = Q_NEG_MIN;
            clipped = 1'b1;
        end
        return nv[Q_W-1:0];
    endfunction

    function automatic void predict_results(input in_item_t req);
        int st, nx, act, cnt, idx;
        int ties [NUM_ACTIONS];
        logic signed [Q_W-1:0] peak;
        logic clipped;
        out_item_t r;
        st = req.state_index % NUM_STATES;
        nx = req.succ_state % NUM_STATES;
        act = req.action % NUM_ACTIONS;
        r = '0;
        r.last = 1'b1;
        if (req.operation == OP_CHOOSE) begin
            r.kind = KIND_CHOOSE;
            if (req.explore_draw < eps_reg) begin
                r.chosen_action = IN_ACT_W'(req.explore_act % NUM_ACTIONS);
                r.explored = 1'b1;
            end else begin
                peak = row_peak(st);
                cnt = 0;
                for (int a = 0; a < NUM_ACTIONS; a++) begin
                    if (q_shadow[st * NUM_ACTIONS + a] == peak) begin
                        ties[cnt] = a;
                        cnt++;
                    end
                end
                r.chosen_action = IN_ACT_W'(ties[req.tie_draw % cnt]);
            end
            pending_results.push_back(r);
        end else begin
            peak = row_peak(nx);
            r.kind = KIND_UPDATE;
            for (int a = 0; a < NUM_ACTIONS; a++) begin
                if (req.update_all || a == act) begin
                    idx = st * NUM_ACTIONS + a;
                    q_shadow[idx] = learned_value(q_shadow[idx], peak, req.reward, clipped);
                    r.chosen_action = IN_ACT_W'(a);
                    r.q_value = q_shadow[idx];
                    r.saturated = clipped;
                    r.last = !req.update_all || a == NUM_ACTIONS - 1;
                    pending_results.push_back(r);
                end
            end
        end
    endfunction

    function automatic in_item_t make_request(
        input logic                    op,
        input logic [IN_STATE_W-1:0]   st,
        input logic [IN_ACT_W-1:0]     act,
        input logic signed [REW_W-1:0] reward,
        input logic [IN_STATE_W-1:0]   nx,
        input logic                    all,
        input logic [DRAW_W-1:0]       draw,
        input logic [IN_ACT_W-1:0]     rnd,
        input logic [DRAW_W-1:0]       tie
    );
        in_item_t req;
        req.operation     = op;
        req.state_index   = st;
        req.action        = act;
        req.reward        = reward;
        req.succ_state    = nx;
        req.update_all    = all;
        req.explore_draw  = draw;
        req.explore_act   = rnd;
        req.tie_draw      = tie;
        return req;
    endfunction

    function automatic in_item_t random_request();
        in_item_t req;
        req.operation     = 1'($urandom_range(1));
        req.state_index   = ($urandom_range(9) < 6) ? 4'($urandom_range(3))
                                                    : 4'($urandom_range(15));
        req.action        = 1'($urandom_range(1));
        req.reward        = 16'($urandom_range(16'hFFFF));
        req.succ_state    = ($urandom_range(9) < 6) ? 4'($urandom_range(3))
                                                    : 4'($urandom_range(15));
        req.update_all    = 1'($urandom_range(1));
        req.explore_draw  = ($urandom_range(3) == 0) ? 16'(eps_reg + $urandom_range(2) - 1)
                                                     : 16'($urandom_range(16'hFFFF));
        req.explore_act   = 1'($urandom_range(1));
        req.tie_draw      = 16'($urandom_range(16'hFFFF));
        return req;
    endfunction

    function automatic in_item_t ramp_request(input logic [IN_STATE_W-1:0] st, input bit down);
        in_item_t req;
        req = random_request();
        req.state_index = st;
        if ($urandom_range(7) == 0) begin
            req.operation = OP_CHOOSE;
            return req;
        end
        req.operation  = OP_UPDATE;
        req.succ_state = st;
        req.update_all = ($urandom_range(3) != 0);
        req.reward     = down ? 16'(-int'($urandom_range(32768, 28672)))
                              : 16'($urandom_range(32767, 28672));
        return req;
    endfunction

    task automatic send_request(input in_item_t req);
        while (gaps_on && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!s_ready);
        predict_results(req);
        request_count++;
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        case (index)
            CFG_EPSILON: eps_reg = value;
            CFG_ALPHA:   alpha_reg = value;
            CFG_GAMMA:   gamma_reg = value;
            default: ;
        endcase
        reg_write_count++;
    endtask

    task automatic program_registers(input logic [COEF_W-1:0] eps,
                                     input logic [COEF_W-1:0] alpha,
                                     input logic [COEF_W-1:0] gamma);
        wait_idle();
        write_register(CFG_SPARE, 16'($urandom_range(16'hFFFF)));
        write_register(CFG_EPSILON, eps);
        write_register(CFG_ALPHA, alpha);
        write_register(CFG_GAMMA, gamma);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_directed();
        send_request(make_request(OP_CHOOSE, 4'd0, 1'b0, '0, 4'd0, 1'b0, 16'hFFFF, 1'b0, 16'd0));
        send_request(make_request(OP_CHOOSE, 4'd0, 1'b0, '0, 4'd0, 1'b0, 16'hFFFF, 1'b0, 16'd1));
        send_request(make_request(OP_CHOOSE, 4'd15, 1'b1, '0, 4'd15, 1'b1, 16'hFFFF, 1'b1,
                                  16'hFFFF));
        send_request(make_request(OP_CHOOSE, 4'd3, 1'b0, '0, 4'd0, 1'b0, 16'd0, 1'b1, 16'd0));
        send_request(make_request(OP_CHOOSE, 4'd3, 1'b0, '0, 4'd0, 1'b0, EPSILON_RST - 16'd1,
                                  1'b0, 16'd0));
        send_request(make_request(OP_CHOOSE, 4'd3, 1'b0, '0, 4'd0, 1'b0, EPSILON_RST, 1'b1,
                                  16'd1));
        send_request(make_request(OP_UPDATE, 4'd0, 1'b1, 16'sh7FFF, 4'd0, 1'b0, '0, 1'b0, '0));
        send_request(make_request(OP_UPDATE, 4'd0, 1'b0, 16'sh8000, 4'd0, 1'b0, '0, 1'b0, '0));
        send_request(make_request(OP_CHOOSE, 4'd0, 1'b0, '0, 4'd0, 1'b0, 16'hFFFF, 1'b0, 16'd0));
        send_request(make_request(OP_CHOOSE, 4'd0, 1'b0, '0, 4'd0, 1'b0, 16'hFFFF, 1'b0, 16'd1));
        send_request(make_request(OP_UPDATE, 4'd15, 1'b0, 16'sh7FFF, 4'd15, 1'b1, '0, 1'b0, '0));
        send_request(make_request(OP_UPDATE, 4'd15, 1'b1, 16'sh8000, 4'd0, 1'b1, '0, 1'b0, '0));
        send_request(make_request(OP_UPDATE, 4'd5, 1'b1, 16'sh0000, 4'd15, 1'b0, '0, 1'b0, '0));
        send_request(make_request(OP_UPDATE, 4'd5, 1'b0, 16'sh0001, 4'd0, 1'b1, '0, 1'b0, '0));
        send_request(make_request(OP_CHOOSE, 4'd15, 1'b0, '0, 4'd0, 1'b0, 16'hFFFF, 1'b0, 16'd1));
        send_request(make_request(OP_CHOOSE, 4'd5, 1'b1, 16'shFFFF, 4'd15, 1'b1, 16'hFFFF, 1'b1,
                                  16'hFFFF));
        send_request(make_request(OP_UPDATE, 4'd7, 1'b0, 16'sh7FFF, 4'd15, 1'b1, 16'hFFFF, 1'b1,
                                  16'hFFFF));
        send_request(make_request(OP_UPDATE, 4'd7, 1'b1, 16'shFFFF, 4'd7, 1'b0, 16'hFFFF, 1'b1,
                                  16'hFFFF));
        wait_idle();
    endtask

    task automatic test_register_extremes();
        program_registers(16'd0, 16'd0, 16'd0);
        send_request(make_request(OP_CHOOSE, 4'd2, 1'b0, '0, 4'd0, 1'b0, 16'd0, 1'b1, 16'd0));
        repeat (14) send_request(random_request());
        program_registers(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_request(make_request(OP_CHOOSE, 4'd0, 1'b0, '0, 4'd0, 1'b0, 16'hFFFE, 1'b0, 16'd0));
        send_request(make_request(OP_CHOOSE, 4'd0, 1'b0, '0, 4'd0, 1'b0, 16'hFFFF, 1'b1, 16'd0));
        repeat (14) send_request(random_request());
        program_registers(16'($urandom_range(16'hFFFF)), 16'($urandom_range(16'hFFFF)),
                          16'($urandom_range(16'hFFFF)));
        repeat (14) send_request(random_request());
        wait_idle();
    endtask

    task automatic test_saturation_ramps();
        program_registers(16'd0, 16'hFFFF, 16'hFFFF);
        repeat (RAMP_LEN) send_request(ramp_request(4'd9, 1'b0));
        repeat (RAMP_LEN) send_request(ramp_request(4'd10, 1'b1));
        wait_idle();
    endtask

    task automatic test_backpressure();
        program_registers(16'd16384, ALPHA_RST, GAMMA_RST);
        rx_hold_left = HOLD_LEN;
        repeat (30) send_request(random_request());
        wait_idle();
    endtask

    task automatic test_random_traffic();
        for (int phase = 0; phase < 5; phase++) begin
            program_registers(16'($urandom_range(16'hFFFF)), 16'($urandom_range(16'hFFFF)),
                              16'($urandom_range(16'hFFFF)));
            gaps_on = (phase != 4);
            repeat (MIX_LEN) send_request(random_request());
        end
        wait_idle();
        gaps_on = 1'b1;
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_register_extremes();
        test_saturation_ramps();
        test_backpressure();
        test_random_traffic();
        wait_idle();
        repeat (16) @(posedge aclk);
        while (pending_results.size() != 0) begin
            report_mismatch("result never delivered", 0, pending_results.pop_front());
        end
        $display("run covered %0d requests and %0d register writes", request_count,
                 reg_write_count);
        $display("choices %0d (explored %0d), updates %0d (clipped %0d)", choose_count,
                 explore_count, update_count, clip_count);
        if (error_count == 0) begin
            $display("q_learning_table_engine_tb: clean");
        end else begin
            $display("q_learning_table_engine_tb: errors");
        end
        $finish;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("timeout with %0d results outstanding", pending_results.size());
        $display("q_learning_table_engine_tb: errors");
        $finish;
    end

endmodule
